>>> hdl/isp_param_vector_mapper_core_assert.svh
// Assertion macros used by the parameter vector mapper datapath.
`ifndef ISP_PARAM_VECTOR_MAPPER_CORE_ASSERT_SVH
`define ISP_PARAM_VECTOR_MAPPER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> hdl/ipvm_pkg.sv
// Package with types, constants and constant tables of the parameter vector mapper.
package ipvm_pkg;

  localparam int unsigned FRAC_BITS   = 15;
  localparam int unsigned ONE         = 1 << FRAC_BITS;
  localparam int unsigned GAMMA_NODES = 64;
  localparam int unsigned CTRL_DEPTH  = 30;
  localparam int unsigned GAMMA_U     = 29;
  localparam int unsigned TONE_BASE   = 1 + GAMMA_NODES;
  localparam int unsigned AFF_BASE    = TONE_BASE + 6;
  localparam int unsigned AFF_COUNT   = 25;
  localparam int unsigned LAST_INDEX  = AFF_BASE + AFF_COUNT;
  localparam int unsigned LOG2_FLOOR  = 1306235;
  localparam int unsigned NEGL_W      = 21;
  localparam int unsigned EXP_W       = 31;
  localparam int unsigned EXP_DEPTH   = 17;
  // Reciprocal of ten scaled by 2^24, rounded down.
  localparam int unsigned RECIP10     = 1677721;
  // Gamma exponent numerator offset: 9 * ONE plus the rounding half of ten.
  localparam int unsigned GAM_OFFSET  = 9 * ONE + 5;

  // Parameter classes by read index.
  localparam logic [1:0] CLS_ZERO  = 2'd0;
  localparam logic [1:0] CLS_GAMMA = 2'd1;
  localparam logic [1:0] CLS_TONE  = 2'd2;
  localparam logic [1:0] CLS_AFF   = 2'd3;

  // Operand sources of the shared divide-by-ten unit.
  localparam logic [1:0] DIV_GAM  = 2'd0;
  localparam logic [1:0] DIV_TONE = 2'd1;
  localparam logic [1:0] DIV_AFF  = 2'd2;

  typedef struct packed {
    logic       accept;
    logic [1:0] div_src;
    logic       div_start;
    logic       div_finish;
    logic       e_mul;
    logic       e_round;
    logic       i_mul0;
    logic       i_mul1;
    logic       g_fin;
    logic       tone_init;
    logic       tone_step;
    logic       emit;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cls;
    logic       tone_edge;
    logic       j_last;
    logic       out_busy;
  } dp_status_t;

  typedef struct packed {
    logic [4:0] src;
    logic [2:0] lo;
    logic [3:0] span;
  } aff_t;

  // Source entry, offset and span (in tenths) of each affine parameter.
  function automatic aff_t aff_entry(input logic [4:0] sel);
    aff_t e;
    e = '{src: 5'd0, lo: 3'd0, span: 4'd0};
    unique case (sel) inside
      [5'd0:5'd11]:
        e = '{src: 5'(sel + 5'd13), lo: 3'd2, span: 4'd7};
      [5'd12:5'd15]:
        e = '{src: 5'(sel + 5'd13), lo: 3'd2, span: 4'd6};
      5'd16: e = '{src: 5'd4,  lo: 3'd0, span: 4'd10};
      5'd17: e = '{src: 5'd5,  lo: 3'd0, span: 4'd9};
      5'd18: e = '{src: 5'd6,  lo: 3'd2, span: 4'd6};
      5'd19: e = '{src: 5'd7,  lo: 3'd1, span: 4'd5};
      5'd20: e = '{src: 5'd8,  lo: 3'd0, span: 4'd6};
      5'd21: e = '{src: 5'd9,  lo: 3'd2, span: 4'd6};
      5'd22: e = '{src: 5'd10, lo: 3'd4, span: 4'd5};
      5'd23: e = '{src: 5'd11, lo: 3'd0, span: 4'd5};
      5'd24: e = '{src: 5'd12, lo: 3'd2, span: 4'd6};
      default: e = '{src: 5'd0, lo: 3'd0, span: 4'd0};
    endcase
    return e;
  endfunction

  // Integer square root, bit by bit; used only to build constant tables.
  function automatic longint unsigned isqrt64(input longint unsigned x_in);
    longint unsigned x;
    longint unsigned r;
    longint unsigned b;
    x = x_in;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    for (int n = 0; n < 32; n++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Base-two logarithm in Q16 by normalizing and 16 truncating squarings.
  function automatic longint unsigned log2_q16(input longint unsigned x);
    int unsigned     n;
    longint unsigned m;
    longint unsigned res;
    n = 0;
    if (x == 0) return 0;
    for (int k = 1; k < 64; k++) begin
      if ((x >> k) != 0) n = k;
    end
    m = (n <= 30) ? (x << (30 - n)) : (x >> (n - 30));
    res = longint'(n) << 16;
    for (int b = 15; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= 64'h8000_0000) begin
        res = res | (64'd1 << b);
        m = m >> 1;
      end
    end
    return res;
  endfunction

  // Negated log2 of the gamma node position in Q16.
  function automatic longint unsigned negl_q16(input int unsigned node);
    longint unsigned a;
    longint unsigned c;
    if (node == 0) return LOG2_FLOOR;
    a = log2_q16(GAMMA_NODES - 1);
    c = log2_q16(node);
    return (a > c) ? a - c : 0;
  endfunction

  // Table of 2^(-k/16) in Q30 from chained square roots.
  function automatic longint unsigned exp_q30(input int unsigned k);
    longint unsigned root [4];
    longint unsigned t;
    root[0] = isqrt64(64'd1 << 59);
    for (int b = 1; b < 4; b++) root[b] = isqrt64(root[b - 1] << 30);
    if (k == 16) return 64'd1 << 29;
    t = 64'd1 << 30;
    for (int b = 0; b < 4; b++) begin
      if (((k >> (3 - b)) & 1) != 0) t = (t * root[b]) >> 30;
    end
    return t;
  endfunction

endpackage

>>> hdl/ipvm_ctrl.sv
// Controller state machine that sequences each read transaction through the datapath.
module ipvm_ctrl import ipvm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic       req_kind,
  output logic       req_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DISP   = 4'd1;
  localparam logic [3:0] ST_G_DIV0 = 4'd2;
  localparam logic [3:0] ST_G_DIV1 = 4'd3;
  localparam logic [3:0] ST_G_MUL  = 4'd4;
  localparam logic [3:0] ST_G_RND  = 4'd5;
  localparam logic [3:0] ST_G_I0   = 4'd6;
  localparam logic [3:0] ST_G_I1   = 4'd7;
  localparam logic [3:0] ST_G_FIN  = 4'd8;
  localparam logic [3:0] ST_T_DIV0 = 4'd9;
  localparam logic [3:0] ST_T_DIV1 = 4'd10;
  localparam logic [3:0] ST_T_MAX  = 4'd11;
  localparam logic [3:0] ST_A_DIV0 = 4'd12;
  localparam logic [3:0] ST_A_DIV1 = 4'd13;
  localparam logic [3:0] ST_DONE   = 4'd14;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       accept;

  // Inputs are taken only between read transactions.
  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;

  // Next state and datapath commands.
  always_comb begin
    state_next        = state;
    cmd               = '0;
    cmd.div_src       = DIV_GAM;
    cmd.accept        = accept;
    unique case (state)
      ST_IDLE: begin
        if (accept && req_kind) state_next = ST_DISP;
      end
      ST_DISP: begin
        unique case (status.cls)
          CLS_GAMMA: state_next = ST_G_DIV0;
          CLS_AFF:   state_next = ST_A_DIV0;
          CLS_TONE: begin
            if (status.tone_edge) begin
              state_next = ST_DONE;
            end else begin
              cmd.tone_init = 1'b1;
              state_next    = ST_T_DIV0;
            end
          end
          default:   state_next = ST_DONE;
        endcase
      end
      ST_G_DIV0: begin
        cmd.div_src   = DIV_GAM;
        cmd.div_start = 1'b1;
        state_next    = ST_G_DIV1;
      end
      ST_G_DIV1: begin
        cmd.div_finish = 1'b1;
        state_next     = ST_G_MUL;
      end
      ST_G_MUL: begin
        cmd.e_mul  = 1'b1;
        state_next = ST_G_RND;
      end
      ST_G_RND: begin
        cmd.e_round = 1'b1;
        state_next  = ST_G_I0;
      end
      ST_G_I0: begin
        cmd.i_mul0 = 1'b1;
        state_next = ST_G_I1;
      end
      ST_G_I1: begin
        cmd.i_mul1 = 1'b1;
        state_next = ST_G_FIN;
      end
      ST_G_FIN: begin
        cmd.g_fin  = 1'b1;
        state_next = ST_DONE;
      end
      ST_T_DIV0: begin
        cmd.div_src   = DIV_TONE;
        cmd.div_start = 1'b1;
        state_next    = ST_T_DIV1;
      end
      ST_T_DIV1: begin
        cmd.div_finish = 1'b1;
        state_next     = ST_T_MAX;
      end
      ST_T_MAX: begin
        cmd.tone_step = 1'b1;
        state_next    = status.j_last ? ST_DONE : ST_T_DIV0;
      end
      ST_A_DIV0: begin
        cmd.div_src   = DIV_AFF;
        cmd.div_start = 1'b1;
        state_next    = ST_A_DIV1;
      end
      ST_A_DIV1: begin
        cmd.div_finish = 1'b1;
        state_next     = ST_DONE;
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hdl/ipvm_datapath.sv
// Datapath: control store, divide-by-ten unit, gamma power unit, tone and output registers.
module ipvm_datapath import ipvm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_kind,
  input  logic [6:0]  req_index,
  input  logic [15:0] req_value,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [6:0]  param_index,
  output logic [15:0] param_value
);

`include "isp_param_vector_mapper_core_assert.svh"

  logic [15:0]         store [CTRL_DEPTH];
  logic [6:0]          idx;
  logic [1:0]          cls;
  logic [2:0]          tone_k;
  logic [4:0]          aff_sel;
  logic [5:0]          node;
  aff_t                aff;
  logic [2:0]          j;
  logic [15:0]         tone_max;
  logic [NEGL_W-1:0]   negl_rom [GAMMA_NODES];
  logic [EXP_W-1:0]    exp_rom [EXP_DEPTH];
  logic [4:0]          rd_addr;
  logic [15:0]         u_rd;
  logic [15:0]         u_gam;
  logic [19:0]         div_x_next;
  logic [19:0]         div_x;
  logic [40:0]         div_p;
  logic [16:0]         q0;
  logic [19:0]         q0x10;
  logic [19:0]         rem;
  logic [16:0]         q;
  logic [19:0]         q_x10;
  logic [37:0]         e_prod;
  logic [21:0]         e16;
  logic [5:0]          p;
  logic [4:0]          fi;
  logic [11:0]         fr;
  logic [43:0]         acc;
  logic [43:0]         acc_sum;
  logic [30:0]         v;
  logic [32:0]         gsh;
  logic [15:0]         g_res;
  logic [19:0]         six_u;
  logic [3:0]          odd;
  logic [19:0]         tone_tmp;
  logic [19:0]         tone_n;
  logic [19:0]         aff_x;
  logic [15:0]         res_value;

  // Constant tables built at elaboration.
  for (genvar g = 0; g < GAMMA_NODES; g++) begin : g_negl
    localparam logic [NEGL_W-1:0] NEGL_VAL = NEGL_W'(negl_q16(g));
    assign negl_rom[g] = NEGL_VAL;
  end
  for (genvar g = 0; g < EXP_DEPTH; g++) begin : g_exp
    localparam logic [EXP_W-1:0] EXP_VAL = EXP_W'(exp_q30(g));
    assign exp_rom[g] = EXP_VAL;
  end

  // Decode of the captured read index.
  always_comb begin
    cls = CLS_ZERO;
    if (idx >= 7'd1 && idx <= 7'(GAMMA_NODES)) begin
      cls = CLS_GAMMA;
    end else if (idx >= 7'(TONE_BASE) && idx < 7'(AFF_BASE)) begin
      cls = CLS_TONE;
    end else if (idx >= 7'(AFF_BASE) && idx < 7'(LAST_INDEX)) begin
      cls = CLS_AFF;
    end
  end
  assign tone_k  = 3'(idx - 7'(TONE_BASE));
  assign aff_sel = 5'(idx - 7'(AFF_BASE));
  assign node    = 6'(idx - 7'd1);
  assign aff     = aff_entry(aff_sel);

  assign status.cls       = cls;
  assign status.tone_edge = (tone_k == 3'd0) || (tone_k == 3'd5);
  assign status.j_last    = (j == tone_k);
  assign status.out_busy  = rsp_valid && rsp_stall;

  // Control store: saturating writes, cleared at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < CTRL_DEPTH; e++) store[e] <= '0;
    end else if (cmd.accept && !req_kind && req_index < 7'(CTRL_DEPTH)) begin
      store[req_index[4:0]] <= (req_value > 16'(ONE)) ? 16'(ONE) : req_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) idx <= req_index;
  end

  // Read port shared by the tone entry and the affine source; the gamma input is read separately.
  assign rd_addr = (cmd.div_src == DIV_TONE) ? 5'(j - 3'd1) : aff.src;
  assign u_rd    = store[rd_addr];
  assign u_gam   = store[GAMMA_U];

  // Tone point numerator, clamped to [0, 10 * ONE].
  always_comb begin
    six_u    = (20'(u_rd) << 2) + (20'(u_rd) << 1);
    odd      = 4'({j, 1'b0}) - 4'd1;
    tone_tmp = six_u + (20'(odd) << FRAC_BITS);
    if (tone_tmp < 20'(2 * ONE)) begin
      tone_n = '0;
    end else if (tone_tmp - 20'(2 * ONE) > 20'(10 * ONE)) begin
      tone_n = 20'(10 * ONE);
    end else begin
      tone_n = tone_tmp - 20'(2 * ONE);
    end
  end

  assign aff_x = (20'(aff.lo) << FRAC_BITS) + 20'(u_rd) * 20'(aff.span) + 20'd5;

  // Dividend select for the divide-by-ten unit.
  always_comb begin
    case (cmd.div_src)
      DIV_GAM:  div_x_next = 20'(GAM_OFFSET) + 20'(u_gam) * 20'd22;
      DIV_TONE: div_x_next = tone_n + 20'd5;
      DIV_AFF:  div_x_next = aff_x;
      default:  div_x_next = '0;
    endcase
  end

  // Divide by ten: reciprocal product, then one correction step.
  assign q0    = div_p[40:24];
  assign q0x10 = 20'(q0) * 20'd10;
  assign rem   = div_x - q0x10;
  assign q_x10 = 20'(q) * 20'd10;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_x <= div_x_next;
      div_p <= 41'(div_x_next) * 41'(RECIP10);
    end
    if (cmd.div_finish) q <= (rem >= 20'd10) ? 17'(q0 + 17'd1) : q0;
  end

  // Gamma power: exponent product, rounding, table interpolation, final scale.
  assign p       = e16[21:16];
  assign fi      = {1'b0, e16[15:12]};
  assign fr      = e16[11:0];
  assign acc_sum = acc + 44'(exp_rom[5'(fi + 5'd1)]) * 44'(fr);

  always_comb begin
    gsh = 33'(v) + (33'd1 << (6'd14 + p));
  end

  always_ff @(posedge clk) begin
    if (cmd.e_mul)   e_prod <= 38'(q) * 38'(negl_rom[node]);
    if (cmd.e_round) e16 <= 22'((e_prod + 38'd32768) >> 16);
    if (cmd.i_mul0)  acc <= 44'(exp_rom[fi]) * 44'(13'd4096 - 13'(fr));
    if (cmd.i_mul1)  v <= 31'(acc_sum >> 12);
    if (cmd.g_fin)   g_res <= (p > 6'd16) ? 16'd0 : 16'(gsh >> (6'd15 + p));
  end

  // Tone loop: running maximum over the inner points.
  always_ff @(posedge clk) begin
    if (rst) begin
      j        <= '0;
      tone_max <= '0;
    end else if (cmd.tone_init) begin
      j        <= 3'd1;
      tone_max <= '0;
    end else if (cmd.tone_step) begin
      j <= 3'(j + 3'd1);
      if (q > 17'(tone_max)) tone_max <= q[15:0];
    end
  end

  // Result select by class.
  always_comb begin
    case (cls)
      CLS_GAMMA: res_value = g_res;
      CLS_AFF:   res_value = q[15:0];
      CLS_TONE: begin
        if (tone_k == 3'd0)      res_value = '0;
        else if (tone_k == 3'd5) res_value = 16'(ONE);
        else                     res_value = tone_max;
      end
      default:   res_value = '0;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      param_index <= idx;
      param_value <= res_value;
    end
  end

  `ASSERT_IMPL(a_emit_free, clk, rst, cmd.emit, !(rsp_valid && rsp_stall))
  `ASSERT_NEXT(a_div_exact, clk, rst, cmd.div_finish, (q_x10 <= div_x) && (div_x - q_x10 < 20'd10))
  `ASSERT_IMPL(a_tone_range, clk, rst, 1'b1, tone_max <= 16'(ONE))

endmodule

>>> hdl/isp_param_vector_mapper_core.sv
// Reads: zero parameters and the tone end points go from dispatch straight to the output;
// affine maps pass once through the divider; inner tone point k makes k divider passes.
// The gamma path runs through a shared divide-by-ten unit and a two-step interpolator.
// A write transaction returns no result.
// One transaction is in work at a time; a finished result may wait while the next is taken.
// Reset clears the control store to zero, returns the controller to idle, drops any result.
module isp_param_vector_mapper_core import ipvm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        kind,
  input  logic [6:0]  index,
  input  logic [15:0] value,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [6:0]  param_index,
  output logic [15:0] param_value
);

  dp_cmd_t    cmd;
  dp_status_t status;

  ipvm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_kind  (kind),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  ipvm_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .req_kind    (kind),
    .req_index   (index),
    .req_value   (value),
    .cmd         (cmd),
    .status      (status),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .param_index (param_index),
    .param_value (param_value)
  );

endmodule
